FILE: rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

  // Store sizing
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int COORD_W  = 32;
  localparam int TOTAL_W  = 11;
  localparam int STATUS_W = 2;
  localparam int POINT_W  = 2 * COORD_W;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ANSWER   = 2'd2;

endpackage : dpc_pkg

`default_nettype wire

FILE: rtl/dominance_point_counter.sv
`default_nettype none

// Two-dimensional dominance counter.
// Input channel: drive in_cmd, in_x_coord, in_y_coord and raise start; the
// transaction is taken at a rising edge where start is high and busy is low.
// in_cmd = insert stores the point (signed coordinates) if fewer than
// CAPACITY points are held; in_cmd = query counts stored points with
// x <= in_x_coord and y <= in_y_coord (inclusive, signed).
// Result channel: out_valid is high for exactly one cycle with
// out_point_total and out_status; the receiver cannot stall, so the result
// must be taken in that cycle. Status: accepted, dropped (store full), answer.
// An insert, or a query on an empty store, gives its result in the
// cycle after acceptance and busy stays low, so one may follow every cycle.
// A query on N stored points holds busy through S_SCAN and S_DRAIN and raises
// its result strobe in the cycle busy falls: one comparator pair walks the
// point memory one entry per cycle through its single registered read port.
// Reset (synchronous, rst_n low) empties the store at once; no clearing pass.

module dominance_point_counter
  import dpc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_cmd,
  input  wire logic signed [COORD_W-1:0]  in_x_coord,
  input  wire logic signed [COORD_W-1:0]  in_y_coord,
  output logic                            out_valid,
  output logic             [TOTAL_W-1:0]  out_point_total,
  output logic             [STATUS_W-1:0] out_status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [ADDR_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]          total_r, total_nxt;
  logic signed [COORD_W-1:0] qx_r, qx_nxt;
  logic signed [COORD_W-1:0] qy_r, qy_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]        out_total_r, out_total_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;

  logic                      wr_en;
  logic                      rd_en;
  logic [POINT_W-1:0]        rd_data;
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic                      hit;
  logic                      scan_last;

  // Point store: x in the upper half, y in the lower half
  dpc_ram #(
    .WIDTH (POINT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data ({in_x_coord, in_y_coord}),
    .rd_en   (rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Shared compare unit on the entry just read
  assign pt_x      = $signed(rd_data[POINT_W-1:COORD_W]);
  assign pt_y      = $signed(rd_data[COORD_W-1:0]);
  assign hit       = rd_vld_r && (pt_x <= qx_r) && (pt_y <= qy_r);
  assign scan_last = ({{(CNT_W-ADDR_W){1'b0}}, idx_r} == (count_r - CNT_W'(1)));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    total_nxt      = total_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_INSERT) begin
            out_valid_nxt = 1'b1;
            out_total_nxt = '0;
            if (count_r < CAP_CNT) begin
              wr_en          = 1'b1;
              count_nxt      = count_r + CNT_W'(1);
              out_status_nxt = ST_ACCEPTED;
            end else begin
              out_status_nxt = ST_DROPPED;
            end
          end else begin
            qx_nxt    = in_x_coord;
            qy_nxt    = in_y_coord;
            total_nxt = '0;
            idx_nxt   = '0;
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_total_nxt  = '0;
              out_status_nxt = ST_ANSWER;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        rd_en      = 1'b1;
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r + ADDR_W'(1);
        if (scan_last) begin
          rd_last_nxt = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last entry to reach the comparator
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Accumulate hits and finish on the last entry
    if (rd_vld_r) begin
      total_nxt = total_r + CNT_W'(hit);
      if (rd_last_r) begin
        out_valid_nxt  = 1'b1;
        out_total_nxt  = TOTAL_W'(total_r + CNT_W'(hit));
        out_status_nxt = ST_ANSWER;
        state_nxt      = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    total_r      <= total_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_point_total = out_total_r;
  assign out_status      = out_status_r;

  // Never present a result while a scan is running
  a_no_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy && out_valid))
    else $error("result strobe while busy");

  // Hold the fill count within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("stored count beyond capacity");

  // Every accepted transaction either answers next cycle or starts a scan
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction neither answered nor scanning");

  // A running total never exceeds the points held
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (total_r <= count_r))
    else $error("running total exceeds stored count");

  // Drop an insert only when the store is full
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_DROPPED)) |-> (count_r == CAP_CNT))
    else $error("insert dropped with room left");

endmodule : dominance_point_counter

`default_nettype wire

FILE: rtl/dpc_ram.sv
`default_nettype none

module dpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : dpc_ram

`default_nettype wire
